// File: design/stss_pkg.sv
// ----------------------------------------------------------------------------
// stss_pkg: shared types and constants of the sorted tab-stop set
// Store sizes, operation codes, sequencer states and the cell control word.
// ----------------------------------------------------------------------------
package stss_pkg;

    localparam int MAX_STOPS   = 64;
    localparam int COLUMN_BITS = 12;
    localparam int IDX_BITS    = $clog2(MAX_STOPS);
    localparam int CNT_BITS    = $clog2(MAX_STOPS + 1);
    localparam int STEP_BITS   = 12;
    localparam int OP_BITS     = 3;
    localparam int EIDX_BITS   = 6;

    localparam int IN_BITS  = OP_BITS + 2 * COLUMN_BITS + STEP_BITS + EIDX_BITS;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 7 + 1 + COLUMN_BITS + 1;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [OP_BITS-1:0] {
        OP_SET_ONE   = 3'd0,
        OP_CLR_ONE   = 3'd1,
        OP_SET_RANGE = 3'd2,
        OP_CLR_RANGE = 3'd3,
        OP_CLR_ALL   = 3'd4,
        OP_READ      = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_APPLY,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic cmp;   // capture compare flags against the key
        logic ins;   // open a slot at the key position and store the key
        logic del;   // close the slot at the key position
    } t_cell_ctl;

endpackage

// File: design/stss_cell.sv
// ----------------------------------------------------------------------------
// stss_cell: one slot of the sorted stop chain
// Holds one column, compares it with the key and shifts toward either neighbor.
// ----------------------------------------------------------------------------
module stss_cell
    import stss_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cell_ctl              i_ctl,
    input  logic [COLUMN_BITS-1:0] i_key,
    input  logic                   i_valid,      // slot lies below the count
    input  logic                   i_prev_below, // left neighbor below key (1 at head)
    input  logic [COLUMN_BITS-1:0] i_prev_val,
    input  logic [COLUMN_BITS-1:0] i_next_val,
    output logic                   o_below,
    output logic                   o_eq,
    output logic [COLUMN_BITS-1:0] o_val
);

    logic [COLUMN_BITS-1:0] r_val, n_val;
    logic                   r_below, r_eq;

    always_comb begin
        n_val = r_val;
        if (i_ctl.ins && !r_below) begin
            // the first slot not below the key takes it, the rest shift right
            n_val = i_prev_below ? i_key : i_prev_val;
        end else if (i_ctl.del && !r_below) begin
            n_val = i_next_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_below <= 1'b0;
            r_eq    <= 1'b0;
        end else if (i_ctl.cmp) begin
            r_below <= i_valid && (r_val < i_key);
            r_eq    <= i_valid && (r_val == i_key);
        end
    end

    assign o_below = r_below;
    assign o_eq    = r_eq;
    assign o_val   = r_val;

endmodule

// File: design/sorted_tab_stop_set_unit.sv
// ----------------------------------------------------------------------------
// sorted_tab_stop_set_unit: ascending duplicate-free tab-stop set
// A single set or clear takes a compare step and an apply step before its result word
// is registered; clear-all, read, unused codes and a range starting past its end go
// straight to the result. A range repeats compare and apply per column visited. One
// word is in work at a time: the next is taken once the last result is registered.
// Reset (synchronous, active low) empties the set; slot contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_tab_stop_set_unit
    import stss_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // op[2:0], column[14:3], end_column[26:15], step[38:27], entry_index[44:39]
    input  logic [IN_W-1:0]  i_s_axis_tdata,
    output logic             o_m_axis_tvalid,
    input  logic             i_m_axis_tready,
    // stop_count[6:0], overflow[7], read_value[19:8], read_valid[20]
    output logic [OUT_W-1:0] o_m_axis_tdata
);

    localparam int C0 = OP_BITS;
    localparam int E0 = C0 + COLUMN_BITS;
    localparam int S0 = E0 + COLUMN_BITS;
    localparam int X0 = S0 + STEP_BITS;

    t_state                 r_state, n_state;
    t_op                    r_op;
    logic [COLUMN_BITS-1:0] r_cur, r_endc;
    logic [STEP_BITS-1:0]   r_step;
    logic [EIDX_BITS-1:0]   r_idx;
    logic [CNT_BITS-1:0]    r_count;
    logic                   r_over;
    logic                   r_out_valid;
    logic [OUT_W-1:0]       r_out_data;

    t_cell_ctl              w_ctl;
    logic [MAX_STOPS-1:0]   w_below, w_eq;
    logic [COLUMN_BITS-1:0] w_val [MAX_STOPS];

    logic                   w_accept, w_emit, w_present, w_full, w_is_set, w_is_clr;
    logic                   w_more;
    logic [COLUMN_BITS:0]   w_next_col;
    logic [COLUMN_BITS-1:0] w_in_col, w_in_endc;
    t_op                    w_in_op;
    logic                   w_rd_valid;
    logic [COLUMN_BITS-1:0] w_rd_value;

    assign w_in_op   = t_op'(i_s_axis_tdata[OP_BITS-1:0]);
    assign w_in_col  = i_s_axis_tdata[E0-1:C0];
    assign w_in_endc = i_s_axis_tdata[S0-1:E0];

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_emit          = (r_state == ST_DONE) && (!r_out_valid || i_m_axis_tready);

    assign w_present  = |w_eq;
    assign w_full     = (r_count == CNT_BITS'(MAX_STOPS));
    assign w_is_set   = (r_op == OP_SET_ONE) || (r_op == OP_SET_RANGE);
    assign w_is_clr   = (r_op == OP_CLR_ONE) || (r_op == OP_CLR_RANGE);
    assign w_next_col = {1'b0, r_cur} + (COLUMN_BITS+1)'(r_step);
    assign w_more     = ((r_op == OP_SET_RANGE) || (r_op == OP_CLR_RANGE))
                        && (r_step != '0) && (w_next_col <= {1'b0, r_endc});

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (w_in_op)
                        OP_SET_ONE, OP_CLR_ONE: n_state = ST_CMP;
                        OP_SET_RANGE, OP_CLR_RANGE:
                            n_state = (w_in_col > w_in_endc) ? ST_DONE : ST_CMP;
                        default: n_state = ST_DONE;
                    endcase
                end
            end
            ST_CMP:   n_state = ST_APPLY;
            ST_APPLY: n_state = w_more ? ST_CMP : ST_DONE;
            ST_DONE:  n_state = w_emit ? ST_IDLE : ST_DONE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // cell controls
    always_comb begin
        w_ctl.cmp = (r_state == ST_CMP);
        w_ctl.ins = (r_state == ST_APPLY) && w_is_set && !w_present && !w_full;
        w_ctl.del = (r_state == ST_APPLY) && w_is_clr && w_present;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op   <= w_in_op;
            r_cur  <= w_in_col;
            r_endc <= w_in_endc;
            r_step <= i_s_axis_tdata[X0-1:S0];
            r_idx  <= i_s_axis_tdata[X0+EIDX_BITS-1:X0];
        end else if ((r_state == ST_APPLY) && w_more) begin
            r_cur <= w_next_col[COLUMN_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_over  <= 1'b0;
        end else begin
            if (w_accept) begin
                r_over <= 1'b0;
                if (w_in_op == OP_CLR_ALL) begin
                    r_count <= '0;
                end
            end
            if (w_ctl.ins) begin
                r_count <= r_count + CNT_BITS'(1);
            end else if (w_ctl.del) begin
                r_count <= r_count - CNT_BITS'(1);
            end
            if ((r_state == ST_APPLY) && w_is_set && !w_present && w_full) begin
                r_over <= 1'b1;
            end
        end
    end

    // cell chain
    for (genvar i = 0; i < MAX_STOPS; i++) begin : g_cell
        logic                   w_prev_below;
        logic [COLUMN_BITS-1:0] w_prev_val, w_next_val;

        if (i == 0) begin : g_head
            assign w_prev_below = 1'b1;
            assign w_prev_val   = '0;
        end else begin : g_body
            assign w_prev_below = w_below[i-1];
            assign w_prev_val   = w_val[i-1];
        end
        if (i == MAX_STOPS - 1) begin : g_tail
            assign w_next_val = '0;
        end else begin : g_inner
            assign w_next_val = w_val[i+1];
        end

        stss_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (w_ctl),
            .i_key        (r_cur),
            .i_valid      (CNT_BITS'(i) < r_count),
            .i_prev_below (w_prev_below),
            .i_prev_val   (w_prev_val),
            .i_next_val   (w_next_val),
            .o_below      (w_below[i]),
            .o_eq         (w_eq[i]),
            .o_val        (w_val[i])
        );
    end

    // read-entry result
    always_comb begin
        w_rd_valid = (r_op == OP_READ) && (CNT_BITS'(r_idx) < r_count);
        w_rd_value = w_rd_valid ? w_val[r_idx[IDX_BITS-1:0]] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_data <= OUT_W'({w_rd_valid, w_rd_value, r_over, 7'(r_count)});
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: stream-level test of the sorted tab-stop set
// Sends set, clear, range, clear-all, read and spare-code commands through the
// slave stream. A local copy of the stop store predicts each result word, and
// every word on the master stream is checked field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import stss_pkg::*;

    // spare op codes: no effect, count reported
    localparam logic [OP_BITS-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OP_BITS-1:0] OP_SPARE_7 = 3'd7;
    localparam int COL_MAX  = (1 << COLUMN_BITS) - 1;
    localparam int COL_POOL = 192;   // narrow column window, so stops collide

    typedef struct {
        logic [OP_BITS-1:0]     op;
        logic [COLUMN_BITS-1:0] column;
        logic [COLUMN_BITS-1:0] end_column;
        logic [STEP_BITS-1:0]   step;
        logic [EIDX_BITS-1:0]   entry_index;
    } t_tab_cmd;

    typedef struct {
        logic [CNT_BITS-1:0]    stop_count;
        logic                   overflow;
        logic [COLUMN_BITS-1:0] read_value;
        logic                   read_valid;
    } t_tab_result;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_s_axis_tvalid;
    logic             o_s_axis_tready;
    // op[2:0], column[14:3], end_column[26:15], step[38:27], entry_index[44:39]
    logic [IN_W-1:0]  i_s_axis_tdata;
    logic             o_m_axis_tvalid;
    logic             i_m_axis_tready;
    // stop_count[6:0], overflow[7], read_value[19:8], read_valid[20]
    logic [OUT_W-1:0] o_m_axis_tdata;

    sorted_tab_stop_set_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // local copy of the stop store
    logic [COLUMN_BITS-1:0] shadow_cols [MAX_STOPS];
    int                     shadow_total;

    t_tab_result pending_results [$];
    int          mismatch_count;
    int          src_idle_pct;
    int          sink_stall_pct;
    int          hold_off_len;
    int          op_seen [8];
    int          dropped_inserts;
    int          read_hits;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Insert in sorted place; return 1 when the store is full and col is new.
    function automatic bit insert_stop(int col);
        int pos = 0;
        while (pos < shadow_total && shadow_cols[pos] < col) pos++;
        if (pos < shadow_total && shadow_cols[pos] == col) return 1'b0;
        if (shadow_total >= MAX_STOPS) return 1'b1;
        for (int k = shadow_total; k > pos; k--) shadow_cols[k] = shadow_cols[k-1];
        shadow_cols[pos] = COLUMN_BITS'(col);
        shadow_total++;
        return 1'b0;
    endfunction

    function automatic void remove_stop(int col);
        int pos = 0;
        while (pos < shadow_total && shadow_cols[pos] < col) pos++;
        if (pos >= shadow_total || shadow_cols[pos] != col) return;
        for (int k = pos; k + 1 < shadow_total; k++) shadow_cols[k] = shadow_cols[k+1];
        shadow_total--;
    endfunction

    function automatic t_tab_result apply_command(t_tab_cmd cmd);
        t_tab_result res;
        int          walk;
        res.overflow   = 1'b0;
        res.read_value = '0;
        res.read_valid = 1'b0;
        case (cmd.op)
            OP_SET_ONE: res.overflow = insert_stop(int'(cmd.column));
            OP_CLR_ONE: remove_stop(int'(cmd.column));
            OP_SET_RANGE, OP_CLR_RANGE: begin
                walk = int'(cmd.column);
                while (walk <= int'(cmd.end_column)) begin
                    if (cmd.op == OP_SET_RANGE) begin
                        if (insert_stop(walk)) res.overflow = 1'b1;
                    end else begin
                        remove_stop(walk);
                    end
                    if (cmd.step == 0) break;
                    walk += int'(cmd.step);
                end
            end
            OP_CLR_ALL: shadow_total = 0;
            OP_READ: begin
                if (cmd.entry_index < shadow_total) begin
                    res.read_value = shadow_cols[cmd.entry_index];
                    res.read_valid = 1'b1;
                end
            end
            default: ;
        endcase
        res.stop_count = CNT_BITS'(shadow_total);
        return res;
    endfunction

    function automatic t_tab_cmd make_cmd(logic [OP_BITS-1:0] op, int col, int endc,
                                          int stp, int idx);
        t_tab_cmd cmd;
        cmd.op          = op;
        cmd.column      = COLUMN_BITS'(col);
        cmd.end_column  = COLUMN_BITS'(endc);
        cmd.step        = STEP_BITS'(stp);
        cmd.entry_index = EIDX_BITS'(idx);
        return cmd;
    endfunction

    function automatic t_tab_cmd random_cmd();
        t_tab_cmd cmd;
        int       pick;
        int       span;
        int       visits;
        pick = int'($urandom_range(99));
        cmd.column      = ($urandom_range(3) == 0) ? COLUMN_BITS'($urandom)
                                                   : COLUMN_BITS'($urandom_range(COL_POOL - 1));
        cmd.end_column  = COLUMN_BITS'($urandom);
        cmd.step        = STEP_BITS'($urandom);
        cmd.entry_index = EIDX_BITS'($urandom);
        if (pick < 30)      cmd.op = OP_SET_ONE;
        else if (pick < 45) cmd.op = OP_CLR_ONE;
        else if (pick < 65) cmd.op = OP_SET_RANGE;
        else if (pick < 77) cmd.op = OP_CLR_RANGE;
        else if (pick < 80) cmd.op = OP_CLR_ALL;
        else if (pick < 97) cmd.op = OP_READ;
        else                cmd.op = pick[0] ? OP_SPARE_6 : OP_SPARE_7;
        if (cmd.op == OP_SET_RANGE || cmd.op == OP_CLR_RANGE) begin
            if ($urandom_range(9) != 0) cmd.step = STEP_BITS'($urandom_range(1, 12));
            // mostly a short walk from the start; otherwise the free end stays
            if ($urandom_range(4) != 0) begin
                span = int'(int'(cmd.step) * $urandom_range(0, 24) + $urandom_range(0, 3));
                cmd.end_column = (int'(cmd.column) + span > COL_MAX)
                                 ? COLUMN_BITS'(COL_MAX)
                                 : COLUMN_BITS'(int'(cmd.column) + span);
            end
            if (cmd.step == 0 || cmd.end_column < cmd.column) visits = 1;
            else visits = (int'(cmd.end_column) - int'(cmd.column)) / int'(cmd.step) + 1;
            // cap the walk length to keep the run short
            if (visits > 100) begin
                cmd.end_column = COLUMN_BITS'(int'(cmd.column) + int'(cmd.step) * 99);
            end
        end
        return cmd;
    endfunction

    // Offer one word, wait for the handshake, then predict its result.
    task automatic send_cmd(t_tab_cmd cmd);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= IN_W'({cmd.entry_index, cmd.step, cmd.end_column,
                                  cmd.column, cmd.op});
        do @(posedge i_clk); while (!o_s_axis_tready);
        op_seen[cmd.op]++;
        pending_results.push_back(apply_command(cmd));
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // sink side: random stalls, plus a long hold-off on request
    initial begin
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_len != 0) begin
                i_m_axis_tready <= 1'b0;
                repeat (hold_off_len) @(posedge i_clk);
                hold_off_len = 0;
            end
            i_m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_tab_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: no result expected, got word %h", $time, o_m_axis_tdata);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("stop_count", 16'(want.stop_count), 16'(o_m_axis_tdata[6:0]));
                check_field("overflow",   16'(want.overflow),   16'(o_m_axis_tdata[7]));
                check_field("read_value", 16'(want.read_value), 16'(o_m_axis_tdata[19:8]));
                check_field("read_valid", 16'(want.read_valid), 16'(o_m_axis_tdata[20]));
                if (want.overflow) dropped_inserts++;
                if (want.read_valid) read_hits++;
            end
        end
    end

    task automatic test_single_stops();
        send_cmd(make_cmd(OP_READ,    0, 0, 1, 0));       // read on an empty set
        send_cmd(make_cmd(OP_SET_ONE, COL_MAX, 0, 1, 0));
        send_cmd(make_cmd(OP_SET_ONE, 0, 0, 1, 0));
        send_cmd(make_cmd(OP_SET_ONE, 0, 0, 1, 0));       // duplicate
        send_cmd(make_cmd(OP_SET_ONE, 2048, 0, 1, 0));
        send_cmd(make_cmd(OP_READ,    0, 0, 1, 0));
        send_cmd(make_cmd(OP_READ,    0, 0, 1, 2));
        send_cmd(make_cmd(OP_READ,    0, 0, 1, 3));       // past the count
        send_cmd(make_cmd(OP_READ,    0, 0, 1, 63));
        send_cmd(make_cmd(OP_CLR_ONE, 2048, 0, 1, 0));
        send_cmd(make_cmd(OP_CLR_ONE, 7, 0, 1, 0));       // absent
        drain_results();
    endtask

    task automatic test_range_walks();
        send_cmd(make_cmd(OP_SET_RANGE, 100, COL_MAX, 0, 0));      // zero step
        send_cmd(make_cmd(OP_SET_RANGE, 200, 100, 1, 0));          // start past end
        send_cmd(make_cmd(OP_SET_RANGE, 5, COL_MAX, COL_MAX, 0));  // next step overshoots
        send_cmd(make_cmd(OP_SET_RANGE, COL_MAX, COL_MAX, COL_MAX, 0));
        send_cmd(make_cmd(OP_CLR_RANGE, 0, COL_MAX, 1365, 0));
        drain_results();
    endtask

    task automatic test_full_store();
        send_cmd(make_cmd(OP_SET_RANGE, 10, COL_MAX, 1, 0));  // fills, then drops
        send_cmd(make_cmd(OP_SET_ONE, 9, 0, 1, 0));            // new column, full
        send_cmd(make_cmd(OP_SET_ONE, 10, 0, 1, 0));           // present, full
        send_cmd(make_cmd(OP_READ, 0, 0, 1, 63));
        send_cmd(make_cmd(OP_CLR_RANGE, 0, COL_MAX, 1, 0));
        drain_results();
    endtask

    task automatic test_spare_and_clear_all();
        send_cmd(make_cmd(OP_SPARE_6, 0, 0, 0, 0));
        send_cmd(make_cmd(OP_SPARE_7, COL_MAX, COL_MAX, COL_MAX, 63));
        send_cmd(make_cmd(OP_SET_ONE, 77, 0, 1, 0));
        send_cmd(make_cmd(OP_CLR_ALL, 77, 0, 1, 0));
        send_cmd(make_cmd(OP_READ, 0, 0, 1, 0));
        drain_results();
    endtask

    task automatic test_random_traffic(int count, int idle_pct, int stall_pct);
        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        repeat (count) send_cmd(random_cmd());
        drain_results();
    endtask

    // hold the sink off so the block fills and stalls its input
    task automatic test_backpressure();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_off_len   = 300;
        repeat (30) send_cmd(random_cmd());
        drain_results();
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        shadow_total    = 0;
        mismatch_count  = 0;
        src_idle_pct    = 0;
        sink_stall_pct  = 0;
        hold_off_len    = 0;
        dropped_inserts = 0;
        read_hits       = 0;
        foreach (op_seen[i]) op_seen[i] = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_single_stops();
        test_range_walks();
        test_full_store();
        test_spare_and_clear_all();
        test_random_traffic(240, 0, 0);
        test_random_traffic(240, 54, 0);
        test_random_traffic(240, 0, 54);
        test_random_traffic(240, 18, 18);
        test_backpressure();
        repeat (20) @(posedge i_clk);

        $display("Covered: set %0d, clear %0d, range set %0d, range clear %0d, clear-all %0d,",
                 op_seen[OP_SET_ONE], op_seen[OP_CLR_ONE], op_seen[OP_SET_RANGE],
                 op_seen[OP_CLR_RANGE], op_seen[OP_CLR_ALL]);
        $display("read %0d, spare %0d; %0d words with a dropped insert, %0d reads of a stop",
                 op_seen[OP_READ], op_seen[OP_SPARE_6] + op_seen[OP_SPARE_7],
                 dropped_inserts, read_hits);
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
